// ===== rtl/mct_pkg.sv =====
// package for the meter change table: item types, command codes, widths
// and reset constants; no dependencies
`timescale 1ns / 1ps

package mct_pkg;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned NUM_W = 8;
  localparam int unsigned DEN_W = 7;
  localparam int unsigned TPQ_W = 16;
  localparam int unsigned PROD_W = NUM_W + TPQ_W;
  localparam int unsigned LEN_W = PROD_W + 2;
  localparam int unsigned DIV_W = 32;

  localparam int unsigned MAX_CHANGES_DEF = 16;

  localparam logic [TPQ_W-1:0] TPQ_RESET = TPQ_W'(480);
  localparam logic [NUM_W-1:0] DEF_NUM = NUM_W'(4);
  localparam logic [DEN_W-1:0] DEF_DEN = DEN_W'(4);

  // raw opcodes on the input channel
  localparam logic [2:0] OPC_ADD = 3'd0;
  localparam logic [2:0] OPC_REMOVE = 3'd1;
  localparam logic [2:0] OPC_CLEAR = 3'd2;
  localparam logic [2:0] OPC_CONST = 3'd3;
  localparam logic [2:0] OPC_QUERY = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_CLEAR,
    OP_CONST,
    OP_QUERY,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [TICK_W-1:0] tick;
    logic [NUM_W-1:0] beats_per_bar;
    logic [DEN_W-1:0] beat_unit;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [NUM_W-1:0]  sig_numerator;
    logic [DEN_W-1:0]  sig_denominator;
    logic [TICK_W-1:0] bar_start;
    logic [TICK_W-1:0] bar_index;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [TICK_W-1:0] tick;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } cmd_t;

  typedef struct packed {
    logic [TICK_W-1:0] at;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_QLOAD,
    ST_QNEXT,
    ST_QMUL,
    ST_QLGO,
    ST_QLWAIT,
    ST_QDGO,
    ST_QDWAIT,
    ST_DONE
  } bk_state_t;

endpackage

// ===== rtl/mct_fifo.sv =====
// two-entry queue used between the front and back parts and on the results
// depends on nothing but its width parameter
`timescale 1ns / 1ps

module mct_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/mct_front.sv =====
// front part: accepts input items, decodes the opcode and queues commands
// depends on mct_pkg and mct_fifo
`timescale 1ns / 1ps

module mct_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  mct_pkg::in_item_t in_item,
  input  logic            cmd_pop,
  output logic            cmd_empty,
  output mct_pkg::cmd_t   cmd
);
  import mct_pkg::*;

  cmd_t dec;
  logic [$bits(cmd_t)-1:0] q_out;

  // classify the opcode
  always_comb begin
    dec.tick = in_item.tick;
    dec.num = in_item.beats_per_bar;
    dec.den = in_item.beat_unit;
    case (in_item.opcode)
      OPC_ADD: dec.op = OP_ADD;
      OPC_REMOVE: dec.op = OP_REMOVE;
      OPC_CLEAR: dec.op = OP_CLEAR;
      OPC_CONST: dec.op = OP_CONST;
      OPC_QUERY: dec.op = OP_QUERY;
      default: dec.op = OP_NOP;
    endcase
  end

  // command queue toward the back part
  mct_fifo #(.W($bits(cmd_t))) u_cmdq (
    .clk(clk),
    .rst_n(rst_n),
    .push(in_push),
    .push_data(dec),
    .full(in_full),
    .pop(cmd_pop),
    .pop_data(q_out),
    .empty(cmd_empty)
  );

  assign cmd = cmd_t'(q_out);

endmodule

// ===== rtl/mct_div.sv =====
// iterative unsigned divider, one quotient bit per cycle
// depends on mct_pkg
`timescale 1ns / 1ps

module mct_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [mct_pkg::DIV_W-1:0] dividend,
  input  logic [mct_pkg::DIV_W-1:0] divisor,
  output logic                    done,
  output logic [mct_pkg::DIV_W-1:0] quot,
  output logic [mct_pkg::DIV_W-1:0] rem
);
  import mct_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DIV_W:0]   rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] dvs_r;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign fits = (rem_sh >= {1'b0, dvs_r});
  assign done = done_r;
  assign quot = quo_r;
  assign rem = rem_r[DIV_W-1:0];

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIV_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // restoring shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/mct_back.sv =====
// back part: holds the sorted change table, applies edits and walks the
// sections for queries; depends on mct_pkg and mct_div
`timescale 1ns / 1ps

module mct_back #(
  parameter int unsigned MAX_CHANGES = mct_pkg::MAX_CHANGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_empty,
  output logic                       cmd_pop,
  input  mct_pkg::cmd_t              cmd,
  output logic                       res_push,
  input  logic                       res_full,
  output mct_pkg::out_item_t         res,
  input  logic                       cfg_we,
  input  logic [mct_pkg::TPQ_W-1:0]  cfg_data
);
  import mct_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHANGES + 1);
  localparam int unsigned IW = (MAX_CHANGES > 1) ? $clog2(MAX_CHANGES) : 1;

  bk_state_t         state_r, state_nxt;
  ent_t              tbl_r [MAX_CHANGES];
  ent_t              tbl_nxt [MAX_CHANGES];
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              add_drop;
  logic [TPQ_W-1:0]  tpq_r;
  cmd_t              cmd_r;
  out_item_t         res_r;

  // query walk registers
  logic [CW-1:0]     i_r;
  logic [TICK_W-1:0] cur_s_r;
  logic [NUM_W-1:0]  cur_num_r;
  logic [DEN_W-1:0]  cur_den_r;
  logic [TICK_W-1:0] nxt_s_r;
  logic              last_r;
  logic              noidx_r;
  logic              inside_r;
  logic [PROD_W-1:0] prod_r;
  logic [LEN_W-1:0]  len_r;
  logic [TICK_W-1:0] idx_r;

  logic [MAX_CHANGES-1:0] vld, mt, lt, geq;
  logic              any_mt;
  ent_t              rd_cur;
  logic [TICK_W-1:0] rd_nxt_at;
  logic [CW-1:0]     i_inc;
  logic              q_inside;
  logic [TICK_W-1:0] q_eff;

  logic              div_start;
  logic [DIV_W-1:0]  div_a, div_b, div_q, div_r;
  logic              div_done;

  assign i_inc = i_r + CW'(1);
  assign rd_cur = tbl_r[i_r[IW-1:0]];
  assign rd_nxt_at = tbl_r[i_inc[IW-1:0]].at;
  assign q_inside = last_r || (cmd_r.tick < nxt_s_r);
  assign q_eff = q_inside ? cmd_r.tick : nxt_s_r;
  assign res = res_r;

  // per-entry match and order against the command tick
  always_comb begin
    for (int i = 0; i < MAX_CHANGES; i++) begin
      vld[i] = (CW'(i) < cnt_r);
      mt[i] = vld[i] && (tbl_r[i].at == cmd_r.tick);
      lt[i] = vld[i] && (tbl_r[i].at < cmd_r.tick);
      geq[i] = 1'b0;
      for (int j = 0; j <= i; j++) geq[i] = geq[i] | mt[j];
    end
    any_mt = |mt;
  end

  // table edit for add, remove, clear and constant meter
  always_comb begin
    for (int i = 0; i < MAX_CHANGES; i++) tbl_nxt[i] = tbl_r[i];
    cnt_nxt = cnt_r;
    add_drop = 1'b0;
    case (cmd_r.op)
      OP_ADD: begin
        if (any_mt) begin
          for (int i = 0; i < MAX_CHANGES; i++) begin
            if (mt[i]) begin
              tbl_nxt[i].num = cmd_r.num;
              tbl_nxt[i].den = cmd_r.den;
            end
          end
        end else if (cnt_r >= CW'(MAX_CHANGES)) begin
          add_drop = 1'b1;
        end else begin
          for (int i = 0; i < MAX_CHANGES; i++) begin
            if (lt[i]) begin
              tbl_nxt[i] = tbl_r[i];
            end else if (i == 0) begin
              tbl_nxt[i] = '{at: cmd_r.tick, num: cmd_r.num, den: cmd_r.den};
            end else if (lt[i-1]) begin
              tbl_nxt[i] = '{at: cmd_r.tick, num: cmd_r.num, den: cmd_r.den};
            end else begin
              tbl_nxt[i] = tbl_r[i-1];
            end
          end
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (any_mt) begin
          for (int i = 0; i < MAX_CHANGES; i++) begin
            if (geq[i]) begin
              if (i + 1 < MAX_CHANGES) tbl_nxt[i] = tbl_r[i+1];
              else tbl_nxt[i] = '0;
            end
          end
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      OP_CONST: begin
        tbl_nxt[0] = '{at: '0, num: cmd_r.num, den: cmd_r.den};
        cnt_nxt = CW'(1);
      end
      default: begin
      end
    endcase
  end

  // divider shared by bar length and section division
  always_comb begin
    div_start = 1'b0;
    div_a = '0;
    div_b = '0;
    case (state_r)
      ST_QLGO: begin
        div_start = (cur_den_r != '0);
        div_a = DIV_W'({prod_r, 2'b00});
        div_b = DIV_W'(cur_den_r);
      end
      ST_QDGO: begin
        div_start = 1'b1;
        div_a = DIV_W'(q_eff - cur_s_r);
        div_b = DIV_W'(len_r);
      end
      default: begin
      end
    endcase
  end

  mct_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .dividend(div_a),
    .divisor(div_b),
    .done(div_done),
    .quot(div_q),
    .rem(div_r)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // next state and handshakes
  always_comb begin
    state_nxt = state_r;
    cmd_pop = 1'b0;
    res_push = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          state_nxt = (cmd.op == OP_QUERY) ? ST_QLOAD : ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_DONE;
      ST_QLOAD: begin
        if (cnt_r == '0) state_nxt = ST_QMUL;
        else if (i_r == '0 && cmd_r.tick < rd_cur.at) state_nxt = ST_QMUL;
        else if (i_inc >= cnt_r) state_nxt = ST_QMUL;
        else state_nxt = ST_QNEXT;
      end
      ST_QNEXT: state_nxt = ST_QMUL;
      ST_QMUL: state_nxt = ST_QLGO;
      ST_QLGO: state_nxt = (cur_den_r == '0) ? ST_QDGO : ST_QLWAIT;
      ST_QLWAIT: if (div_done) state_nxt = ST_QDGO;
      ST_QDGO: state_nxt = ST_QDWAIT;
      ST_QDWAIT: begin
        if (div_done) state_nxt = inside_r ? ST_DONE : ST_QLOAD;
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ticks per quarter register
  always_ff @(posedge clk) begin
    if (!rst_n) tpq_r <= TPQ_RESET;
    else if (cfg_we) tpq_r <= cfg_data;
  end

  // change table and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CW'(1);
      tbl_r[0] <= '{at: '0, num: DEF_NUM, den: DEF_DEN};
    end else if (state_r == ST_EXEC) begin
      cnt_r <= cnt_nxt;
      for (int i = 0; i < MAX_CHANGES; i++) tbl_r[i] <= tbl_nxt[i];
    end
  end

  // command latch, query walk and result
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cmd_r <= cmd;
        res_r <= '0;
        i_r <= '0;
        idx_r <= '0;
        noidx_r <= 1'b0;
      end
      ST_EXEC: res_r.status <= add_drop;
      ST_QLOAD: begin
        if (cnt_r == '0) begin
          cur_s_r <= '0;
          cur_num_r <= DEF_NUM;
          cur_den_r <= DEF_DEN;
          last_r <= 1'b1;
        end else if (i_r == '0 && cmd_r.tick < rd_cur.at) begin
          cur_s_r <= '0;
          cur_num_r <= rd_cur.num;
          cur_den_r <= rd_cur.den;
          last_r <= 1'b1;
          noidx_r <= 1'b1;
        end else begin
          cur_s_r <= rd_cur.at;
          cur_num_r <= rd_cur.num;
          cur_den_r <= rd_cur.den;
          last_r <= (i_inc >= cnt_r);
        end
      end
      ST_QNEXT: nxt_s_r <= rd_nxt_at;
      ST_QMUL: prod_r <= PROD_W'(cur_num_r * tpq_r);
      ST_QLGO: if (cur_den_r == '0) len_r <= LEN_W'(1);
      ST_QLWAIT: begin
        if (div_done) len_r <= (div_q == '0) ? LEN_W'(1) : div_q[LEN_W-1:0];
      end
      ST_QDGO: inside_r <= q_inside;
      ST_QDWAIT: begin
        if (div_done) begin
          if (!noidx_r) idx_r <= idx_r + div_q;
          if (inside_r) begin
            res_r.sig_numerator <= cur_num_r;
            res_r.sig_denominator <= cur_den_r;
            res_r.bar_start <= cmd_r.tick - div_r;
            res_r.bar_index <= noidx_r ? idx_r : idx_r + div_q;
          end else begin
            i_r <= i_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/meter_change_table_core.sv =====
// top level of the meter change table: front decoder, back table engine
// and result queue; depends on mct_pkg, mct_front, mct_back and mct_fifo
`timescale 1ns / 1ps

// Usage
//   Input queue: drive in_item and raise in_push; the item is taken on a
//   clock edge where in_full is low. Results come out in order as a queue:
//   out_item is valid while out_empty is low and leaves on out_pop.
//   Every item gives exactly one result.
//   cfg_we with cfg_data writes ticks per quarter (reset 480).
// Sequencing
//   Edits (add, remove, clear, constant meter, unknown) pass through the
//   execute state to the done state, which pushes the result. The engine
//   finishes one item before it takes the next. A query walks the sections
//   one at a time; each section uses the shared divider, which produces
//   one quotient bit per cycle (bar length, then section bar count).
// Reset
//   Synchronous, active low; table holds one change at tick 0 in 4/4.
// Stalls
//   A two-entry command queue and a two-entry result queue decouple the
//   sides; when results are not popped the engine holds its result and
//   the command queue fills, then in_full rises.
module meter_change_table_core #(
  parameter int unsigned MAX_CHANGES = mct_pkg::MAX_CHANGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  mct_pkg::in_item_t         in_item,
  output logic                      out_empty,
  input  logic                      out_pop,
  output mct_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [mct_pkg::TPQ_W-1:0] cfg_data
);
  import mct_pkg::*;

  cmd_t      cmd;
  logic      cmd_empty;
  logic      cmd_pop;
  out_item_t res;
  logic      res_push;
  logic      res_full;
  logic [$bits(out_item_t)-1:0] res_q;

  // decode and command queue
  mct_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_item(in_item),
    .cmd_pop(cmd_pop),
    .cmd_empty(cmd_empty),
    .cmd(cmd)
  );

  // table engine
  mct_back #(.MAX_CHANGES(MAX_CHANGES)) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cmd_empty(cmd_empty),
    .cmd_pop(cmd_pop),
    .cmd(cmd),
    .res_push(res_push),
    .res_full(res_full),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  // result queue
  mct_fifo #(.W($bits(out_item_t))) u_resq (
    .clk(clk),
    .rst_n(rst_n),
    .push(res_push),
    .push_data(res),
    .full(res_full),
    .pop(out_pop),
    .pop_data(res_q),
    .empty(out_empty)
  );

  assign out_item = out_item_t'(res_q);

endmodule
